### design/utf8t_pkg.sv
package utf8t_pkg;

  // field widths
  localparam int CpWidth    = 21;
  localparam int OctetWidth = 8;

  // register index of the mode register
  localparam logic REG_DIRECTION_MODE = 1'b0;

  typedef logic [CpWidth-1:0]    cp_t;
  typedef logic [OctetWidth-1:0] octet_t;

  typedef enum logic {
    MODE_DECODE = 1'b0,
    MODE_ENCODE = 1'b1
  } mode_t;

  // decoder view of the item at the head
  typedef struct packed {
    logic emit;
    cp_t  value;
  } dec_out_t;

  // encoder view of the byte selected by the byte index
  typedef struct packed {
    octet_t octet;
    logic   last;
  } enc_out_t;

endpackage

### design/utf8t_decoder.sv
module utf8t_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  logic               step,
  input  utf8t_pkg::octet_t  octet,
  input  logic               end_in,
  output utf8t_pkg::dec_out_t res
);
  import utf8t_pkg::*;

  logic [1:0] pending;
  logic [1:0] pending_next;
  cp_t        acc;
  cp_t        acc_next;

  // lead classification or continuation merge
  always_comb begin
    acc_next     = acc;
    pending_next = 2'd0;
    if (pending == 2'd0) begin
      acc_next = {{(CpWidth-OctetWidth){1'b0}}, octet};
      if (octet[7:5] == 3'b110) begin
        acc_next     = {{(CpWidth-5){1'b0}}, octet[4:0]};
        pending_next = 2'd1;
      end else if (octet[7:4] == 4'b1110) begin
        acc_next     = {{(CpWidth-4){1'b0}}, octet[3:0]};
        pending_next = 2'd2;
      end else if (octet[7:3] == 5'b11110) begin
        acc_next     = {{(CpWidth-3){1'b0}}, octet[2:0]};
        pending_next = 2'd3;
      end
    end else begin
      acc_next     = {acc[CpWidth-7:0], octet[5:0]};
      pending_next = pending - 2'd1;
    end
  end

  assign res.emit  = (pending_next == 2'd0) || end_in;
  assign res.value = acc_next;

  // sequence state
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      pending <= 2'd0;
      acc     <= '0;
    end else if (step) begin
      acc     <= acc_next;
      pending <= res.emit ? 2'd0 : pending_next;
    end
  end

endmodule

### design/utf8t_encoder.sv
module utf8t_encoder (
  input  utf8t_pkg::cp_t      code,
  input  logic [1:0]          idx,
  output utf8t_pkg::enc_out_t res
);
  import utf8t_pkg::*;

  octet_t     seq [4];
  logic [1:0] last_idx;

  // byte sequence by code point range
  always_comb begin
    seq[0] = '0;
    seq[1] = '0;
    seq[2] = '0;
    seq[3] = '0;
    if (code[20:7] == '0) begin
      seq[0]   = code[7:0];
      last_idx = 2'd0;
    end else if (code[20:11] == '0) begin
      seq[0]   = {3'b110, code[10:6]};
      seq[1]   = {2'b10, code[5:0]};
      last_idx = 2'd1;
    end else if (code[20:16] == '0) begin
      seq[0]   = {4'b1110, code[15:12]};
      seq[1]   = {2'b10, code[11:6]};
      seq[2]   = {2'b10, code[5:0]};
      last_idx = 2'd2;
    end else begin
      seq[0]   = {5'b11110, code[20:18]};
      seq[1]   = {2'b10, code[17:12]};
      seq[2]   = {2'b10, code[11:6]};
      seq[3]   = {2'b10, code[5:0]};
      last_idx = 2'd3;
    end
  end

  assign res.octet = seq[idx];
  assign res.last  = (idx == last_idx);

endmodule

### design/utf8_transcoder_top.sv
// path: an accepted request passes through the input register, then the result
//   register; decode results leave through both after the last byte of a sequence
// throughput: decode 1 byte per cycle; encode one output byte per cycle through the
//   single result register, holding each code point until its last byte; both while out_ready does not stall
// reset: synchronous active-high rst empties both registers, clears the decode
//   state and sets direction_mode to decode
module utf8_transcoder_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  utf8t_pkg::cp_t in_value,
  input  logic           in_end,
  output logic           out_valid,
  input  logic           out_ready,
  output utf8t_pkg::cp_t out_value,
  output logic           out_run_last,
  output logic           out_string_last,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import utf8t_pkg::*;

  mode_t      mode;
  logic       cfg_write;
  logic       inq_valid;
  cp_t        inq_value;
  logic       inq_end;
  logic [1:0] idx;
  logic       out_free;
  logic       item_done;
  logic       load_out;
  dec_out_t   dec_res;
  enc_out_t   enc_res;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_DIRECTION_MODE);
  assign prdata    = (paddr[2] == REG_DIRECTION_MODE) ? {31'b0, mode} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_DECODE;
    end else if (cfg_write) begin
      mode <= mode_t'(pwdata[0]);
    end
  end

  // handshake and sequencing
  assign out_free  = !out_valid || out_ready;
  assign item_done = inq_valid && ((mode == MODE_ENCODE) ? (out_free && enc_res.last)
                                                         : (out_free || !dec_res.emit));
  assign load_out  = inq_valid && out_free && ((mode == MODE_ENCODE) || dec_res.emit);
  assign in_ready  = !inq_valid || item_done;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_ready) begin
      inq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_value <= in_value;
      inq_end   <= in_end;
    end
  end

  utf8t_decoder u_decoder (
    .clk    (clk),
    .rst    (rst),
    .clear  (cfg_write),
    .step   (item_done && (mode == MODE_DECODE)),
    .octet  (inq_value[OctetWidth-1:0]),
    .end_in (inq_end),
    .res    (dec_res)
  );

  utf8t_encoder u_encoder (
    .code (inq_value),
    .idx  (idx),
    .res  (enc_res)
  );

  // byte index within the current encoded sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (load_out && (mode == MODE_ENCODE)) begin
      idx <= enc_res.last ? 2'd0 : idx + 2'd1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= load_out;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (mode == MODE_ENCODE) begin
        out_value       <= {{(CpWidth-OctetWidth){1'b0}}, enc_res.octet};
        out_run_last    <= enc_res.last;
        out_string_last <= enc_res.last && inq_end;
      end else begin
        out_value       <= dec_res.value;
        out_run_last    <= 1'b1;
        out_string_last <= inq_end;
      end
    end
  end

endmodule

### design/utf8t_checker.sv
module utf8t_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input utf8t_pkg::cp_t out_value,
  input logic           out_run_last,
  input logic           out_string_last,
  input logic [31:0]    prdata,
  input logic           pready
);
  import utf8t_pkg::*;

  // both registers come out of reset empty
  assert property (@(posedge clk) rst |=> (in_ready && !out_valid))
    else $error("not empty after reset");

  // a held result keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_value)
                                   && $stable(out_run_last) && $stable(out_string_last)))
    else $error("held result changed");

  // end of string only on the last result of a request
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_string_last) |-> out_run_last)
    else $error("string end without run end");

  // register readback carries only the mode bit, port never stalls
  assert property (@(posedge clk) disable iff (rst)
    pready && (prdata[31:1] == '0))
    else $error("bad config port response");

endmodule

bind utf8_transcoder_top utf8t_checker u_utf8t_checker (
  .clk             (clk),
  .rst             (rst),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_value       (out_value),
  .out_run_last    (out_run_last),
  .out_string_last (out_string_last),
  .prdata          (prdata),
  .pready          (pready)
);
